/* rtl/core/pts_pkg.sv */
`timescale 1ns / 1ps

package pts_pkg;

  localparam int NumPrioDef  = 32;
  localparam int NumTasksDef = 32;
  localparam int TidW        = 5;
  localparam int PrioInW     = 5;
  localparam int DelayW      = 32;
  localparam int DepthW      = 8;
  localparam int ActW        = 4;
  localparam logic [DepthW-1:0] LockMax = 8'd255;

  typedef enum logic [ActW-1:0] {
    ACT_CREATE    = 4'd0,
    ACT_DELAY     = 4'd1,
    ACT_DELAY_DN  = 4'd2,
    ACT_SUSPEND   = 4'd3,
    ACT_WAKE      = 4'd4,
    ACT_DELETE    = 4'd5,
    ACT_DEL_REQ   = 4'd6,
    ACT_DEL_CUR   = 4'd7,
    ACT_LOCK      = 4'd8,
    ACT_UNLOCK    = 4'd9,
    ACT_SCHEDULE  = 4'd10,
    ACT_QUERY     = 4'd11
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LINK,
    ST_SCHED,
    ST_OUT
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic link;
    logic sched;
    logic finish;
  } pts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dummy_ok;
  } pts_stat_t;

endpackage

/* rtl/core/pts_ctrl.sv */
`timescale 1ns / 1ps

module pts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  pts_pkg::pts_stat_t stat,
  output pts_pkg::pts_cmd_t  cmd
);
  import pts_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // hold state and output flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequence one command: decode, relink, schedule, publish
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_stall      = 1'b1;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = ST_LINK;
      end
      ST_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = ST_SCHED;
      end
      ST_SCHED: begin
        cmd.sched = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall || stat.dummy_ok && 1'b0) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/pts_dp.sv */
`timescale 1ns / 1ps

module pts_dp #(
  parameter int NUM_PRIO  = pts_pkg::NumPrioDef,
  parameter int NUM_TASKS = pts_pkg::NumTasksDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pts_pkg::pts_cmd_t               cmd,
  output pts_pkg::pts_stat_t              stat,
  input  logic [pts_pkg::ActW-1:0]        in_action,
  input  logic [pts_pkg::TidW-1:0]        in_task_id,
  input  logic [pts_pkg::PrioInW-1:0]     in_task_prio,
  input  logic [pts_pkg::DelayW-1:0]      in_delay_ticks,
  output logic                            out_switch_now,
  output logic [pts_pkg::TidW-1:0]        out_next_task,
  output logic                            out_any_ready,
  output logic                            out_status,
  output logic [pts_pkg::PrioInW-1:0]     out_query_prio,
  output logic                            out_query_delayed,
  output logic                            out_query_suspended,
  output logic [pts_pkg::DepthW-1:0]      out_query_suspend_count,
  output logic [pts_pkg::DelayW-1:0]      out_query_delay,
  output logic                            out_query_delete_req,
  output logic [pts_pkg::DepthW-1:0]      out_lock_depth
);
  import pts_pkg::*;

  localparam int PW = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;
  localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);

  // per-priority and per-task storage
  logic [NUM_PRIO-1:0]  ready_r;
  logic [TW-1:0]        head_r  [NUM_PRIO];
  logic [TW-1:0]        tail_r  [NUM_PRIO];
  logic [CW-1:0]        count_r [NUM_PRIO];
  logic [TW-1:0]        next_r  [NUM_TASKS];
  logic [TW-1:0]        prev_r  [NUM_TASKS];
  logic [PW-1:0]        prio_r  [NUM_TASKS];
  logic [NUM_TASKS-1:0] f_ex_r, f_dly_r, f_sus_r, f_dreq_r;
  logic [DepthW-1:0]    sdep_r  [NUM_TASKS];
  logic [DelayW-1:0]    dval_r  [NUM_TASKS];
  logic [DepthW-1:0]    lock_r;
  logic [TW-1:0]        run_r;
  logic                 run_v_r;

  // latched command
  action_t              act_r;
  logic [TidW-1:0]      tid_in_r;
  logic [PrioInW-1:0]   prio_in_r;
  logic [DelayW-1:0]    ticks_r;

  // decode results
  logic                 ign_r, do_app_r, do_rem_r, do_sched_r, was_run_r;
  logic [TW-1:0]        t_r;
  logic                 q_r;

  // result staging, copied to the outputs when the result is published
  logic                 sw_r;
  logic [PrioInW-1:0]   qp_r;
  logic                 qd_r, qs_r, qdr_r;
  logic [DepthW-1:0]    qc_r;
  logic [DelayW-1:0]    qdl_r;

  // decode (combinational on latched command)
  logic          tid_ok, live, queued, rv_ok;
  logic [TW-1:0] td;
  logic          ign_c, app_c, rem_c, sch_c, wr_c;

  always_comb begin
    tid_ok = ({27'd0, tid_in_r} < 32'(NUM_TASKS));
    td     = TW'(tid_in_r);
    rv_ok  = run_v_r && f_ex_r[run_r];
    if (act_r == ACT_DEL_CUR) td = run_r;
    live   = tid_ok && f_ex_r[td];
    queued = f_ex_r[td] && !f_dly_r[td] && !f_sus_r[td];
    ign_c = 1'b0; app_c = 1'b0; rem_c = 1'b0; sch_c = 1'b0; wr_c = 1'b0;
    unique case (act_r)
      ACT_CREATE: begin
        ign_c = !tid_ok || live || ({27'd0, prio_in_r} >= 32'(NUM_PRIO));
        app_c = !ign_c;
      end
      ACT_DELAY: begin
        ign_c = !live || !queued;
        rem_c = !ign_c;
      end
      ACT_DELAY_DN: begin
        ign_c = !live || !f_dly_r[td];
        app_c = !ign_c;
      end
      ACT_SUSPEND: begin
        ign_c = !live || f_dly_r[td] || sdep_r[td] >= LockMax;
        rem_c = !ign_c && sdep_r[td] == '0 && queued;
        sch_c = !ign_c && sdep_r[td] == '0 && run_v_r && run_r == td;
      end
      ACT_WAKE: begin
        ign_c = !live || !f_sus_r[td] || sdep_r[td] == '0;
        app_c = !ign_c && sdep_r[td] == DepthW'(1);
        sch_c = app_c;
      end
      ACT_DELETE: begin
        ign_c = !live;
        rem_c = !ign_c && queued;
        wr_c  = run_v_r && run_r == td;
        sch_c = !ign_c && wr_c;
      end
      ACT_DEL_REQ:  ign_c = !live;
      ACT_DEL_CUR: begin
        ign_c = !rv_ok;
        rem_c = !ign_c && queued;
        wr_c  = 1'b1;
        sch_c = !ign_c;
      end
      ACT_LOCK:     ign_c = 1'b0;
      ACT_UNLOCK: begin
        ign_c = lock_r == '0;
        sch_c = lock_r == DepthW'(1);
      end
      ACT_SCHEDULE: sch_c = 1'b1;
      ACT_QUERY:    ign_c = !live;
      default:      ign_c = 1'b1;
    endcase
  end

  // lowest set ready bit
  logic [PW-1:0] hp;
  logic          hp_v;
  always_comb begin
    hp = '0;
    hp_v = 1'b0;
    for (int i = NUM_PRIO - 1; i >= 0; i--) begin
      if (ready_r[i]) begin
        hp = PW'(i);
        hp_v = 1'b1;
      end
    end
  end

  // link step values
  logic [PW-1:0] lp;
  logic [TW-1:0] lnx, lpv;
  assign lp  = prio_r[t_r];
  assign lnx = next_r[t_r];
  assign lpv = prev_r[t_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r  <= '0;
      f_ex_r   <= '0;
      f_dly_r  <= '0;
      f_sus_r  <= '0;
      f_dreq_r <= '0;
      lock_r   <= '0;
      run_r    <= '0;
      run_v_r  <= 1'b0;
      for (int i = 0; i < NUM_PRIO; i++) count_r[i] <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        sdep_r[i] <= '0;
        dval_r[i] <= '0;
      end
    end else begin
      // capture the transfer
      if (cmd.load) begin
        act_r     <= action_t'(in_action);
        tid_in_r  <= in_task_id;
        prio_in_r <= in_task_prio;
        ticks_r   <= in_delay_ticks;
        sw_r      <= 1'b0;
      end
      // register decode and update flags
      if (cmd.decode) begin
        ign_r      <= ign_c;
        do_app_r   <= app_c;
        do_rem_r   <= rem_c;
        do_sched_r <= sch_c;
        was_run_r  <= wr_c;
        t_r        <= td;
        q_r        <= act_r == ACT_QUERY && !ign_c;
        qp_r       <= PrioInW'(prio_r[td]);
        qd_r       <= f_dly_r[td];
        qs_r       <= f_sus_r[td];
        qc_r       <= sdep_r[td];
        qdl_r      <= dval_r[td];
        qdr_r      <= f_dreq_r[td];
        if (!ign_c) begin
          unique case (act_r)
            ACT_CREATE: begin
              prio_r[td] <= PW'(prio_in_r);
              f_ex_r[td] <= 1'b1;
              sdep_r[td] <= '0;
              dval_r[td] <= '0;
            end
            ACT_DELAY: begin
              dval_r[td]  <= ticks_r;
              f_dly_r[td] <= 1'b1;
            end
            ACT_DELAY_DN: f_dly_r[td] <= 1'b0;
            ACT_SUSPEND: begin
              sdep_r[td]  <= sdep_r[td] + DepthW'(1);
              f_sus_r[td] <= 1'b1;
            end
            ACT_WAKE: begin
              sdep_r[td] <= sdep_r[td] - DepthW'(1);
              if (sdep_r[td] == DepthW'(1)) f_sus_r[td] <= 1'b0;
            end
            ACT_DELETE, ACT_DEL_CUR: begin
              f_ex_r[td]   <= 1'b0;
              f_dly_r[td]  <= 1'b0;
              f_sus_r[td]  <= 1'b0;
              f_dreq_r[td] <= 1'b0;
              sdep_r[td]   <= '0;
              dval_r[td]   <= '0;
              if (wr_c) run_v_r <= 1'b0;
            end
            ACT_DEL_REQ: f_dreq_r[td] <= 1'b1;
            ACT_LOCK:    if (lock_r < LockMax) lock_r <= lock_r + DepthW'(1);
            ACT_UNLOCK:  lock_r <= lock_r - DepthW'(1);
            default: ;
          endcase
        end
      end
      // relink the FIFO of the task's priority
      if (cmd.link) begin
        if (do_app_r) begin
          if (count_r[lp] == '0) head_r[lp] <= t_r;
          else begin
            next_r[tail_r[lp]] <= t_r;
            prev_r[t_r]        <= tail_r[lp];
          end
          tail_r[lp]  <= t_r;
          count_r[lp] <= count_r[lp] + CW'(1);
          ready_r[lp] <= 1'b1;
        end else if (do_rem_r && count_r[lp] != '0) begin
          if (head_r[lp] == t_r) head_r[lp] <= lnx;
          else next_r[lpv] <= lnx;
          if (tail_r[lp] == t_r) tail_r[lp] <= lpv;
          else prev_r[lnx] <= lpv;
          count_r[lp] <= count_r[lp] - CW'(1);
          if (count_r[lp] == CW'(1)) ready_r[lp] <= 1'b0;
        end
      end
      // scheduling pass
      if (cmd.sched) begin
        if (do_sched_r && lock_r == '0 && hp_v &&
            (!run_v_r || run_r != head_r[hp])) begin
          run_r   <= head_r[hp];
          run_v_r <= 1'b1;
          sw_r    <= 1'b1;
        end
      end
      // publish the result
      if (cmd.finish) begin
        out_switch_now          <= sw_r;
        out_next_task           <= hp_v ? TidW'(head_r[hp]) : '0;
        out_any_ready           <= hp_v;
        out_status              <= ign_r;
        out_lock_depth          <= lock_r;
        out_query_prio          <= q_r ? qp_r : '0;
        out_query_delayed       <= q_r && qd_r;
        out_query_suspended     <= q_r && qs_r;
        out_query_suspend_count <= q_r ? qc_r : '0;
        out_query_delay         <= q_r ? qdl_r : '0;
        out_query_delete_req    <= q_r && qdr_r;
      end
    end
  end

  assign stat.dummy_ok = was_run_r;

endmodule

/* rtl/core/priority_task_scheduler.sv */
`timescale 1ns / 1ps
// Bitmap priority task scheduler: one command in, one result out. Each command runs through
// five steps (capture, decode with flag update, FIFO relink, scheduling pass, result
// register) run by a controller over a register-based datapath; a new command is taken
// only after the previous result is registered, so commands never overlap, and the result
// step waits while a held result is stalled. Result fields stay stable while that lasts.
module priority_task_scheduler #(
  parameter int NUM_PRIO  = pts_pkg::NumPrioDef,
  parameter int NUM_TASKS = pts_pkg::NumTasksDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pts_pkg::ActW-1:0]        in_action,
  input  logic [pts_pkg::TidW-1:0]        in_task_id,
  input  logic [pts_pkg::PrioInW-1:0]     in_task_prio,
  input  logic [pts_pkg::DelayW-1:0]      in_delay_ticks,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_switch_now,
  output logic [pts_pkg::TidW-1:0]        out_next_task,
  output logic                            out_any_ready,
  output logic                            out_status,
  output logic [pts_pkg::PrioInW-1:0]     out_query_prio,
  output logic                            out_query_delayed,
  output logic                            out_query_suspended,
  output logic [pts_pkg::DepthW-1:0]      out_query_suspend_count,
  output logic [pts_pkg::DelayW-1:0]      out_query_delay,
  output logic                            out_query_delete_req,
  output logic [pts_pkg::DepthW-1:0]      out_lock_depth
);
  import pts_pkg::*;

  pts_cmd_t  cmd;
  pts_stat_t stat;

  pts_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  pts_dp #(.NUM_PRIO(NUM_PRIO), .NUM_TASKS(NUM_TASKS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_action, .in_task_id, .in_task_prio,
    .in_delay_ticks, .out_switch_now, .out_next_task, .out_any_ready, .out_status,
    .out_query_prio, .out_query_delayed, .out_query_suspended,
    .out_query_suspend_count, .out_query_delay, .out_query_delete_req,
    .out_lock_depth
  );

  // one command step active at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("overlapping command steps");

  // no new transfer accepted while the block is busy
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decode |-> in_stall) else $error("input accepted mid-command");

  // a result is never published over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.finish) else $error("result overwritten");

endmodule

/* sim/priority_task_scheduler_tb.sv */
`timescale 1ns / 1ps

module priority_task_scheduler_tb;
  import pts_pkg::*;

  localparam int NTASK = 32;
  localparam int NPRIO = 32;
  localparam logic [3:0] FL_LIVE = 4'b0001;
  localparam logic [3:0] FL_DLY  = 4'b0010;
  localparam logic [3:0] FL_SUSP = 4'b0100;
  localparam logic [3:0] FL_DREQ = 4'b1000;

  typedef struct packed {
    logic        sw;
    logic [4:0]  nxt;
    logic        rdy;
    logic        st;
    logic [4:0]  qprio;
    logic        qdly;
    logic        qsusp;
    logic [7:0]  qcnt;
    logic [31:0] qdelay;
    logic        qdreq;
    logic [7:0]  lock;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ActW-1:0] in_action = '0;
  logic [TidW-1:0] in_task_id = '0;
  logic [PrioInW-1:0] in_task_prio = '0;
  logic [DelayW-1:0] in_delay_ticks = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_switch_now, out_any_ready, out_status;
  logic out_query_delayed, out_query_suspended, out_query_delete_req;
  logic [TidW-1:0] out_next_task;
  logic [PrioInW-1:0] out_query_prio;
  logic [DepthW-1:0] out_query_suspend_count, out_lock_depth;
  logic [DelayW-1:0] out_query_delay;

  priority_task_scheduler uut (.*);

  // scheduler shadow state
  logic [31:0] ready_map;
  logic [4:0]  q_head [NPRIO];
  logic [4:0]  q_tail [NPRIO];
  logic [5:0]  q_cnt  [NPRIO];
  logic [4:0]  nxt_of [NTASK];
  logic [4:0]  prv_of [NTASK];
  logic [4:0]  prio_of [NTASK];
  logic [3:0]  flags  [NTASK];
  logic [7:0]  susp_cnt [NTASK];
  logic [31:0] delay_of [NTASK];
  logic [7:0]  lock_cnt;
  logic [4:0]  cur_task;
  logic        cur_valid;

  sched_result_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_sent = 0;
  bit idle_on = 1'b1;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit is_queued(input int t);
    return (flags[t] & (FL_LIVE | FL_DLY | FL_SUSP)) == FL_LIVE;
  endfunction

  // append a task to the tail of its priority FIFO
  function automatic void fifo_push(input int t);
    int p;
    p = prio_of[t];
    if (q_cnt[p] == 0) begin
      q_head[p] = t[4:0];
    end else begin
      nxt_of[q_tail[p]] = t[4:0];
      prv_of[t] = q_tail[p];
    end
    q_tail[p] = t[4:0];
    q_cnt[p]++;
    ready_map[p] = 1'b1;
  endfunction

  // unlink a task from its priority FIFO
  function automatic void fifo_unlink(input int t);
    int p;
    p = prio_of[t];
    if (q_cnt[p] == 0) return;
    if (q_head[p] == t) q_head[p] = nxt_of[t];
    else nxt_of[prv_of[t]] = nxt_of[t];
    if (q_tail[p] == t) q_tail[p] = prv_of[t];
    else prv_of[nxt_of[t]] = prv_of[t];
    q_cnt[p]--;
    if (q_cnt[p] == 0) ready_map[p] = 1'b0;
  endfunction

  function automatic bit top_ready(output logic [4:0] t);
    t = '0;
    for (int p = 0; p < NPRIO; p++) begin
      if (ready_map[p]) begin
        t = q_head[p];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit run_pass();
    logic [4:0] t;
    if (lock_cnt != 0 || !top_ready(t)) return 1'b0;
    if (!cur_valid || cur_task != t) begin
      cur_task = t;
      cur_valid = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit remove_task(input int t);
    bit was_cur;
    was_cur = cur_valid && cur_task == t;
    if (is_queued(t)) fifo_unlink(t);
    flags[t] = '0;
    susp_cnt[t] = '0;
    delay_of[t] = '0;
    if (was_cur) begin
      cur_valid = 1'b0;
      return run_pass();
    end
    return 1'b0;
  endfunction

  function automatic void clear_shadow();
    ready_map = '0;
    lock_cnt = '0;
    cur_task = '0;
    cur_valid = 1'b0;
    for (int i = 0; i < 32; i++) begin
      q_head[i] = '0; q_tail[i] = '0; q_cnt[i] = '0;
      nxt_of[i] = '0; prv_of[i] = '0; prio_of[i] = '0;
      flags[i] = '0; susp_cnt[i] = '0; delay_of[i] = '0;
    end
  endfunction

  // compute the result of one command and advance the shadow state
  function automatic sched_result_t apply_command(input logic [3:0] act, input int t,
                                                  input int p, input logic [31:0] ticks);
    sched_result_t r;
    bit live;
    logic [4:0] h;
    r = '0;
    live = flags[t][0];
    case (act)
      ACT_CREATE: begin
        if (live) r.st = 1'b1;
        else begin
          prio_of[t] = p[4:0];
          flags[t] = FL_LIVE;
          susp_cnt[t] = '0;
          delay_of[t] = '0;
          fifo_push(t);
        end
      end
      ACT_DELAY: begin
        if (!live || !is_queued(t)) r.st = 1'b1;
        else begin
          fifo_unlink(t);
          delay_of[t] = ticks;
          flags[t] |= FL_DLY;
        end
      end
      ACT_DELAY_DN: begin
        if (!live || !flags[t][1]) r.st = 1'b1;
        else begin
          flags[t] &= ~FL_DLY;
          fifo_push(t);
        end
      end
      ACT_SUSPEND: begin
        if (!live || flags[t][1] || susp_cnt[t] == 8'd255) r.st = 1'b1;
        else begin
          susp_cnt[t]++;
          if (susp_cnt[t] == 1) begin
            flags[t] |= FL_SUSP;
            fifo_unlink(t);
            if (cur_valid && cur_task == t) r.sw = run_pass();
          end
        end
      end
      ACT_WAKE: begin
        if (!live || !flags[t][2] || susp_cnt[t] == 0) r.st = 1'b1;
        else begin
          susp_cnt[t]--;
          if (susp_cnt[t] == 0) begin
            flags[t] &= ~FL_SUSP;
            fifo_push(t);
            r.sw = run_pass();
          end
        end
      end
      ACT_DELETE: begin
        if (!live) r.st = 1'b1;
        else r.sw = remove_task(t);
      end
      ACT_DEL_REQ: begin
        if (!live) r.st = 1'b1;
        else flags[t] |= FL_DREQ;
      end
      ACT_DEL_CUR: begin
        if (!cur_valid || !flags[cur_task][0]) r.st = 1'b1;
        else r.sw = remove_task(cur_task);
      end
      ACT_LOCK: begin
        if (lock_cnt != 8'd255) lock_cnt++;
      end
      ACT_UNLOCK: begin
        if (lock_cnt == 0) r.st = 1'b1;
        else begin
          lock_cnt--;
          if (lock_cnt == 0) r.sw = run_pass();
        end
      end
      ACT_SCHEDULE: r.sw = run_pass();
      ACT_QUERY: begin
        if (!live) r.st = 1'b1;
        else begin
          r.qprio = prio_of[t];
          r.qdly = flags[t][1];
          r.qsusp = flags[t][2];
          r.qcnt = susp_cnt[t];
          r.qdelay = delay_of[t];
          r.qdreq = flags[t][3];
        end
      end
      default: r.st = 1'b1;
    endcase
    void'(top_ready(h));
    r.nxt = h;
    r.rdy = ready_map != 0;
    r.lock = lock_cnt;
    return r;
  endfunction

  // send one command; prediction happens at the accepting edge
  // valid stays high between back-to-back commands and drops only while idling
  task automatic send_cmd(input logic [3:0] act, input int t, input int p = 0,
                          input logic [31:0] ticks = '0);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_task_id <= t[4:0];
    in_task_prio <= p[4:0];
    in_delay_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(apply_command(act, t, p, ticks));
    n_sent++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h", n_results, what,
             got, want);
    errors++;
  endtask

  // check each result transfer against the oldest prediction
  always @(posedge clk) begin
    sched_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        e = expected_q.pop_front();
        if (out_switch_now !== e.sw) report_mismatch("switch_now", out_switch_now, e.sw);
        if (out_next_task !== e.nxt) report_mismatch("next_task", out_next_task, e.nxt);
        if (out_any_ready !== e.rdy) report_mismatch("any_ready", out_any_ready, e.rdy);
        if (out_status !== e.st) report_mismatch("status", out_status, e.st);
        if (out_query_prio !== e.qprio) report_mismatch("query_prio", out_query_prio, e.qprio);
        if (out_query_delayed !== e.qdly)
          report_mismatch("query_delayed", out_query_delayed, e.qdly);
        if (out_query_suspended !== e.qsusp)
          report_mismatch("query_suspended", out_query_suspended, e.qsusp);
        if (out_query_suspend_count !== e.qcnt)
          report_mismatch("query_suspend_count", out_query_suspend_count, e.qcnt);
        if (out_query_delay !== e.qdelay)
          report_mismatch("query_delay", out_query_delay, e.qdelay);
        if (out_query_delete_req !== e.qdreq)
          report_mismatch("query_delete_req", out_query_delete_req, e.qdreq);
        if (out_lock_depth !== e.lock) report_mismatch("lock_depth", out_lock_depth, e.lock);
      end
      n_results++;
    end
  end

  // random stall bursts on the result side
  initial begin
    @(posedge rst_n);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic test_extremes();
    send_cmd(ACT_QUERY, 0);
    send_cmd(ACT_UNLOCK, 0);
    send_cmd(ACT_DEL_CUR, 0);
    send_cmd(ACT_CREATE, 31, 31);
    send_cmd(ACT_CREATE, 31, 2);
    send_cmd(ACT_CREATE, 0, 0);
    send_cmd(ACT_CREATE, 5, 0);
    send_cmd(ACT_SCHEDULE, 0);
    send_cmd(ACT_DELAY, 0, 0, 32'hFFFF_FFFF);
    send_cmd(ACT_QUERY, 0);
    send_cmd(ACT_SUSPEND, 0);
    send_cmd(ACT_DELAY, 0, 0, 32'h1);
    send_cmd(ACT_DELAY_DN, 0);
    send_cmd(ACT_DELAY_DN, 0);
    send_cmd(ACT_WAKE, 5);
    send_cmd(ACT_SUSPEND, 5);
    send_cmd(ACT_SUSPEND, 5);
    send_cmd(ACT_QUERY, 5);
    send_cmd(ACT_WAKE, 5);
    send_cmd(ACT_WAKE, 5);
    send_cmd(ACT_DEL_REQ, 31);
    send_cmd(ACT_QUERY, 31);
    send_cmd(ACT_DELETE, 0);
    send_cmd(ACT_DEL_CUR, 0);
    send_cmd(4'd12, 3);
    send_cmd(4'd15, 3);
  endtask

  // drive one task's suspend count and the lock depth to saturation and back
  task automatic test_saturation();
    send_cmd(ACT_CREATE, 9, 4);
    for (int i = 0; i < 256; i++) send_cmd(ACT_SUSPEND, 9);
    send_cmd(ACT_QUERY, 9);
    for (int i = 0; i < 255; i++) send_cmd(ACT_WAKE, 9);
    for (int i = 0; i < 257; i++) send_cmd(ACT_LOCK, 0);
    send_cmd(ACT_SCHEDULE, 0);
    for (int i = 0; i < 256; i++) send_cmd(ACT_UNLOCK, 0);
  endtask

  // random commands biased toward defined actions and low task ids
  task automatic test_random(input int count);
    int a, t;
    for (int i = 0; i < count; i++) begin
      a = $urandom_range(0, 15);
      if (a > 11 && $urandom_range(0, 3) != 0) a = $urandom_range(0, 11);
      t = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 31);
      if (a == ACT_LOCK && lock_cnt > 3 && $urandom_range(0, 1)) a = ACT_UNLOCK;
      send_cmd(a[3:0], t, $urandom_range(0, 31), $urandom());
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    clear_shadow();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_saturation();
    test_random(150);
    idle_on = 1'b0;
    test_random(50);
    wait_drain();
    $display("ran %0d commands, %0d results checked, all actions and saturations hit",
             n_sent, n_results);
    if (errors == 0) begin
      $display("priority_task_scheduler_tb: PASS");
    end else begin
      $display("priority_task_scheduler_tb: FAIL");
    end
    $finish;
  end

  // timeout
  initial begin
    #4ms;
    $display("priority_task_scheduler_tb: FAIL");
    $finish;
  end

endmodule
